// ===== src/pcs_pkg.sv =====
// shared constants, operation codes and types of the program counter and call stack unit
package pcs_pkg;

    localparam int ADDR_W      = 16;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LEVEL_W     = 4;
    localparam int OP_W        = 3;
    localparam int STEP_W      = 16;
    localparam int BYTE_W      = 8;

    localparam logic [PTR_W-1:0]  PTR_LAST     = PTR_W'(STACK_DEPTH - 1);
    localparam logic [BYTE_W-1:0] OPC_LONG     = 8'h01;
    localparam logic [BYTE_W-1:0] OPC_FX_FIRST = 8'hF0;
    localparam logic [BYTE_W-1:0] OPC_FX_LAST  = 8'hF3;
    localparam logic [ADDR_W-1:0] INC_SHORT    = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] INC_LONG     = ADDR_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_CALL   = 3'd0,
        OP_RETURN = 3'd1,
        OP_SKIP   = 3'd2,
        OP_JUMP   = 3'd3,
        OP_STEP   = 3'd4
    } op_t;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PTR_W-1:0]  ptr_t;

endpackage

// ===== src/program_counter_call_stack_unit_top.sv =====
// program counter and return-address stack, one control transaction per cycle unless stalled
// pipeline: an accepted transaction is registered into the update stage (stack read at accept),
//   then into the output register, which holds the result until it is taken
// throughput: one transaction per cycle unless m_ready stalls the output; the stack read
//   issued at accept and the call write-back from the update stage share the cycle on
//   separate ports, a same-entry overlap is forwarded
// reset: aresetn synchronous active low; counter, stack pointer, pipeline valids and the
//   per-entry valid bits of the stack clear at once, an unwritten stack entry reads as zero
module program_counter_call_stack_unit_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pcs_pkg::OP_W-1:0]    s_operation,
    input  logic [pcs_pkg::ADDR_W-1:0]  s_target_address,
    input  logic signed [pcs_pkg::STEP_W-1:0] s_step_amount,
    input  logic [pcs_pkg::BYTE_W-1:0]  s_next_opcode_byte,
    input  logic [pcs_pkg::BYTE_W-1:0]  s_next_operand_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcs_pkg::ADDR_W-1:0]  m_program_counter,
    output logic                        m_loop_flag,
    output logic [pcs_pkg::LEVEL_W-1:0] m_stack_level
);
    import pcs_pkg::*;

    // architectural state: counter and stack pointer
    addr_t pc_reg;
    ptr_t  sp_reg, sp_next;

    // return stack memory plus per-entry valid bits (reset value of an entry is zero)
    addr_t                  stack_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] vld_reg;
    addr_t                  rd_mem_reg;

    // read-side bypass captured at accept time
    logic  rd_fwd_reg;
    logic  rd_zero_reg;
    addr_t fwd_data_reg;

    // update stage registers
    logic  b_valid_reg;
    op_t   b_op_reg;
    addr_t b_target_reg;
    addr_t b_step_m2_reg;
    logic  b_step_zero_reg;
    logic  b_skip_long_reg;
    ptr_t  b_sp_reg;
    ptr_t  b_wr_addr_reg;

    // output register
    logic  m_valid_reg;
    addr_t m_pc_reg;
    logic  m_flag_reg;
    ptr_t  m_sp_reg;

    // stage A combinational
    op_t   op_in;
    logic  s_accept;
    ptr_t  sp_inc, sp_dec;
    addr_t step_m2;
    logic  skip_long;
    logic  b_advance;

    // stage B combinational
    logic  wr_en;
    addr_t ret_data;
    addr_t addend;
    addr_t pc_sum;
    addr_t pc_m2;
    addr_t pc_res;
    logic  flag_res;

    logic [PTR_W+LEVEL_W-1:0] level_ext;

    // handshake: the update stage drains into the output register when it is free or taken
    assign b_advance = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !b_valid_reg || b_advance;
    assign s_accept  = s_valid && s_ready;

    assign op_in  = op_t'(s_operation);
    assign sp_inc = (sp_reg == PTR_LAST) ? '0 : sp_reg + ptr_t'(1);
    assign sp_dec = (sp_reg == '0) ? PTR_LAST : sp_reg - ptr_t'(1);

    // step operation adds (step - 2); the signed step is sign-extended to the address width
    assign step_m2 = addr_t'(s_step_amount) - INC_SHORT;

    // skip distance decode: long skip over a 4-byte instruction
    always_comb begin
        if (s_next_opcode_byte == OPC_LONG) begin
            skip_long = 1'b1;
        end else if (s_next_opcode_byte >= OPC_FX_FIRST && s_next_opcode_byte <= OPC_FX_LAST) begin
            skip_long = (s_next_operand_byte == '0);
        end else begin
            skip_long = 1'b0;
        end
    end

    always_comb begin
        unique case (op_in)
            OP_CALL:   sp_next = sp_inc;
            OP_RETURN: sp_next = sp_dec;
            default:   sp_next = sp_reg;
        endcase
    end

    // call writes the counter that stands before the call back into the stack
    assign wr_en = b_advance && (b_op_reg == OP_CALL);

    // stack memory: one write port from the update stage, one registered read at accept
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[b_wr_addr_reg] <= pc_reg;
        end
        if (s_accept) begin
            rd_mem_reg <= stack_mem[sp_dec];
        end
    end

    // stage A: capture the transaction, stack pointer moves right away
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            b_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            if (wr_en) begin
                vld_reg[b_wr_addr_reg] <= 1'b1;
            end
            if (s_accept) begin
                sp_reg      <= sp_next;
                b_valid_reg <= 1'b1;
            end else if (b_advance) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_op_reg        <= op_in;
            b_target_reg    <= s_target_address;
            b_step_m2_reg   <= step_m2;
            b_step_zero_reg <= (s_step_amount == '0);
            b_skip_long_reg <= skip_long;
            b_sp_reg        <= sp_next;
            b_wr_addr_reg   <= sp_reg;
            // a call finishing this cycle may write the entry being read
            rd_fwd_reg      <= wr_en && (b_wr_addr_reg == sp_dec);
            rd_zero_reg     <= !vld_reg[sp_dec];
            fwd_data_reg    <= pc_reg;
        end
    end

    // stage B: one add for skip and step, one subtract for the self-jump check
    always_comb begin
        if (rd_fwd_reg) begin
            ret_data = fwd_data_reg;
        end else if (rd_zero_reg) begin
            ret_data = '0;
        end else begin
            ret_data = rd_mem_reg;
        end
    end

    assign addend = (b_op_reg == OP_SKIP) ? (b_skip_long_reg ? INC_LONG : INC_SHORT)
                                          : b_step_m2_reg;
    assign pc_sum = pc_reg + addend;
    assign pc_m2  = pc_reg - INC_SHORT;

    always_comb begin
        pc_res   = pc_reg;
        flag_res = 1'b0;
        unique case (b_op_reg)
            OP_CALL: begin
                pc_res = b_target_reg;
            end
            OP_RETURN: begin
                pc_res = ret_data;
            end
            OP_SKIP: begin
                pc_res = pc_sum;
            end
            OP_JUMP: begin
                if (pc_m2 == b_target_reg) begin
                    flag_res = 1'b1;
                end else begin
                    pc_res = b_target_reg;
                end
            end
            OP_STEP: begin
                if (b_step_zero_reg) begin
                    flag_res = 1'b1;
                end else begin
                    pc_res = pc_sum;
                end
            end
            default: begin
                pc_res   = pc_reg;
                flag_res = 1'b0;
            end
        endcase
    end

    // counter commit and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_advance) begin
                pc_reg      <= pc_res;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_advance) begin
            m_pc_reg   <= pc_res;
            m_flag_reg <= flag_res;
            m_sp_reg   <= b_sp_reg;
        end
    end

    assign level_ext         = {{LEVEL_W{1'b0}}, m_sp_reg};
    assign m_valid           = m_valid_reg;
    assign m_program_counter = m_pc_reg;
    assign m_loop_flag       = m_flag_reg;
    assign m_stack_level     = level_ext[LEVEL_W-1:0];

`ifndef SYNTHESIS
    // a call never reports a self-loop
    a_call_no_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        b_advance && (b_op_reg == OP_CALL) |=> m_valid_reg && !m_flag_reg)
        else $error("call produced a loop flag");

    // a flagged result leaves the counter where it was
    a_flag_holds_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        b_advance && flag_res |=> pc_reg == $past(pc_reg))
        else $error("loop flag with a moved counter");

    // forwarded read data only arises from a call write-back in the same cycle
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !wr_en |=> !rd_fwd_reg)
        else $error("forward without a write");
`endif

endmodule
